// ===== src/lis_pkg.sv =====
// shared constants, types and state codes for the longest increasing subsequence unit
`timescale 1ns / 1ps

package lis_pkg;

  // capacity of the value store
  localparam int unsigned MaxLen  = 1024;
  localparam int unsigned AddrW   = $clog2(MaxLen);
  localparam int unsigned CntW    = $clog2(MaxLen + 1);
  localparam int unsigned LenW    = CntW;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OutLenW = 11;
  localparam int unsigned EntryW  = LenW + ValueW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_EMIT
  } lis_state_e;

  // control of the shared compare/max unit
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctrl_t;

endpackage

// ===== src/lis_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module lis_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lis_scan.sv =====
// shared compare and max unit that builds the ending length of one value
`timescale 1ns / 1ps

module lis_scan import lis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scan_ctrl_t               ctrl_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic signed [ValueW-1:0] rd_value_i,
  input  logic        [LenW-1:0]   rd_len_i,
  output logic        [LenW-1:0]   len_o
);

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cand;

  // candidate from one earlier entry, taken when it is smaller and longer
  always_comb begin
    cand  = rd_len_i + LenW'(1);
    len_d = len_q;
    if (ctrl_i.start) begin
      len_d = LenW'(1);
    end else if (ctrl_i.step && (rd_value_i < value_i) && (cand > len_q)) begin
      len_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
    end else begin
      len_q <= len_d;
    end
  end

  assign len_o = len_q;

endmodule

// ===== src/longest_increasing_subsequence_unit.sv =====
// top level: sequencer, value store and result register of the lis unit
// an item accepted with n > 0 values stored passes through scan, drain and write before ready again:
// the scan reads each stored entry in turn through the single read port, then the drain, then the write
// the first item of a sequence goes straight to the write; an item beyond capacity only sets the overflow flag
// an item marked last adds the emit state, which waits while an untaken result holds the output
// reset clears count, overflow flag and result valid, and sets best length to 1
`timescale 1ns / 1ps

module longest_increasing_subsequence_unit import lis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,   // value[31:0]
  input  logic                     s_axis_tlast,   // last
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata,   // lis_length[10:0], zero fill
  output logic                     m_axis_tuser    // too_long
);

  lis_state_e state_q, state_d;

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     last_q, last_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [LenW-1:0]          best_q, best_d;
  logic                     ovf_q, ovf_d;
  logic [AddrW-1:0]         idx_q, idx_d;
  logic                     rd_vld_q;
  logic                     out_vld_q, out_vld_d;
  logic [OutLenW-1:0]       out_len_q, out_len_d;
  logic                     out_ovf_q, out_ovf_d;

  logic               s_xfer;
  logic               re;
  logic               we;
  logic [EntryW-1:0]  rd_entry;
  logic [LenW-1:0]    len;
  scan_ctrl_t         scan_ctrl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // value store: ending length above the value
  lis_ram #(
    .Width(EntryW),
    .Depth(MaxLen)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i({len, value_q}),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rd_entry)
  );

  assign scan_ctrl.start = s_xfer;
  assign scan_ctrl.step  = rd_vld_q;

  lis_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .value_i   (value_q),
    .rd_value_i(rd_entry[ValueW-1:0]),
    .rd_len_i  (rd_entry[EntryW-1:ValueW]),
    .len_o     (len)
  );

  // sequencer next state and controls
  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    last_d    = last_q;
    count_d   = count_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    out_len_d = out_len_q;
    out_ovf_d = out_ovf_q;
    re        = 1'b0;
    we        = 1'b0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          value_d = s_axis_tdata;
          last_d  = s_axis_tlast;
          idx_d   = '0;
          if (count_q == CntW'(MaxLen)) begin
            ovf_d   = 1'b1;
            state_d = s_axis_tlast ? ST_EMIT : ST_IDLE;
          end else if (count_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        re    = 1'b1;
        idx_d = idx_q + AddrW'(1);
        if (CntW'(idx_q) == count_q - CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        we      = 1'b1;
        count_d = count_q + CntW'(1);
        if (len > best_q) begin
          best_d = len;
        end
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_len_d = best_q[OutLenW-1:0];
          out_ovf_d = ovf_q;
          count_d   = '0;
          best_d    = LenW'(1);
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      best_q    <= LenW'(1);
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      rd_vld_q  <= re;
      out_vld_q <= out_vld_d;
      last_q    <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16 - OutLenW){1'b0}}, out_len_q};
  assign m_axis_tuser  = out_ovf_q;

  // store writes stay inside capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) we |-> (count_q < CntW'(MaxLen)))
    else $error("store write beyond capacity");

  // a scan never reads at or past the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CntW'(idx_q) < count_q))
    else $error("scan read past stored entries");

  // best length is 1 or bounded by the number of stored values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_q == LenW'(1)) || (CntW'(best_q) <= count_q))
    else $error("best length exceeds stored count");

  // the emit state is reached only for an item marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == ST_EMIT) |-> last_q
    || $past(s_xfer && s_axis_tlast))
    else $error("emit without last item");

endmodule
